[hw/rtl/slxfr_pkg.sv]
package slxfr_pkg;

	// Field widths
	localparam int unsigned ByteW  = 8;
	localparam int unsigned PosW   = 9;
	localparam int unsigned PhaseW = 3;

	// Phase codes, as seen on the phase output and held in the state
	localparam logic [PhaseW-1:0] PH_HUNT     = 3'd0;
	localparam logic [PhaseW-1:0] PH_LENGTH   = 3'd1;
	localparam logic [PhaseW-1:0] PH_TYPE     = 3'd2;
	localparam logic [PhaseW-1:0] PH_PAYLOAD  = 3'd3;
	localparam logic [PhaseW-1:0] PH_CHECKSUM = 3'd4;
	localparam logic [PhaseW-1:0] PH_COMPLETE = 3'd5;
	localparam logic [PhaseW-1:0] PH_ERROR    = 3'd6;

	// Sync, length, type and checksum bytes around the payload
	localparam logic [PosW-1:0] FrameOverhead = 9'd4;

	// Configuration register indexes and reset values
	localparam logic CFG_SYNC_VALUE     = 1'b0;
	localparam logic CFG_FRAME_CAPACITY = 1'b1;
	localparam logic [ByteW-1:0] SyncReset     = 8'hA4;
	localparam logic [PosW-1:0]  CapacityReset = 9'd259;

	// Receiver state carried from byte to byte
	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic [ByteW-1:0]  remaining;
		logic [ByteW-1:0]  length;
		logic [ByteW-1:0]  xor_acc;
		logic [PosW-1:0]   position;
	} rx_state_t;

	// One result beat
	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic              byte_valid;
		logic [PosW-1:0]   byte_index;
		logic [ByteW-1:0]  out_byte;
		logic              frame_done;
		logic              frame_error;
		logic [PosW-1:0]   frame_length;
	} rx_result_t;

endpackage

[hw/rtl/sync_length_xor_frame_receiver_unit.sv]
// Sync / length / XOR-checksum frame receiver.
// Input channel: one received byte per beat on rx_byte (in_valid/in_ready).
// Output channel: one result beat per input byte (out_valid/out_ready),
//   carrying the phase, the byte with its frame position when it belongs
//   to a frame, and on the checksum byte a done or error mark; frame_length
//   is the whole frame size on done and zero otherwise.
// Config channel: cfg_index 0 is the sync byte, 1 the frame capacity in
//   bytes; writes are taken in the cycle they are offered. Writes are to
//   be made while idle, which the block itself does not enforce.
// Path: input register, deframing step, then result register.
// Throughput: one byte per cycle while out_ready stays high; the state
//   update is a single step of narrow logic between the two registers.
// Reset: receiver hunts for sync, sync byte 0xA4, capacity 259, both
//   stages empty.
// Stall: when out_ready is low the result register holds, the input
//   register fills, and in_ready drops until the result is taken.
module sync_length_xor_frame_receiver_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [slxfr_pkg::ByteW-1:0]         rx_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [slxfr_pkg::PhaseW-1:0]        phase,
	output logic                                byte_valid,
	output logic [slxfr_pkg::PosW-1:0]          byte_index,
	output logic [slxfr_pkg::ByteW-1:0]         out_byte,
	output logic                                frame_done,
	output logic                                frame_error,
	output logic [slxfr_pkg::PosW-1:0]          frame_length,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [slxfr_pkg::PosW-1:0]          cfg_data
);

	logic [slxfr_pkg::ByteW-1:0] sync_value_q;
	logic [slxfr_pkg::PosW-1:0]  frame_capacity_q;

	logic                        valid_s1;
	logic [slxfr_pkg::ByteW-1:0] byte_s1;

	slxfr_pkg::rx_state_t  state_q;
	slxfr_pkg::rx_state_t  state_nxt;
	slxfr_pkg::rx_result_t res_nxt;
	slxfr_pkg::rx_result_t res_q;
	logic                  res_valid_q;

	logic adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q     <= slxfr_pkg::SyncReset;
			frame_capacity_q <= slxfr_pkg::CapacityReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				slxfr_pkg::CFG_SYNC_VALUE:     sync_value_q     <= cfg_data[slxfr_pkg::ByteW-1:0];
				slxfr_pkg::CFG_FRAME_CAPACITY: frame_capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	slxfr_step u_step (
		.cur            (state_q),
		.rx_byte        (byte_s1),
		.sync_value     (sync_value_q),
		.frame_capacity (frame_capacity_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// receiver state advances once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid    = res_valid_q;
	assign phase        = res_q.phase;
	assign byte_valid   = res_q.byte_valid;
	assign byte_index   = res_q.byte_index;
	assign out_byte     = res_q.out_byte;
	assign frame_done   = res_q.frame_done;
	assign frame_error  = res_q.frame_error;
	assign frame_length = res_q.frame_length;

endmodule

[hw/rtl/slxfr_step.sv]
// Per-byte deframing step: next state and result from the current state.
module slxfr_step (
	input  slxfr_pkg::rx_state_t             cur,
	input  logic [slxfr_pkg::ByteW-1:0]      rx_byte,
	input  logic [slxfr_pkg::ByteW-1:0]      sync_value,
	input  logic [slxfr_pkg::PosW-1:0]       frame_capacity,
	output slxfr_pkg::rx_state_t             nxt,
	output slxfr_pkg::rx_result_t            res
);

	logic [slxfr_pkg::PosW-1:0] pos_inc;
	logic [slxfr_pkg::PosW-1:0] total;
	logic                       sum_ok;
	logic                       fits;

	assign pos_inc = cur.position + 9'd1;
	assign total   = {1'b0, cur.length} + slxfr_pkg::FrameOverhead;
	assign sum_ok  = (rx_byte == cur.xor_acc);
	assign fits    = (total <= frame_capacity);

	always_comb begin
		nxt = cur;
		res = '0;
		res.out_byte = rx_byte;
		case (cur.phase)
			slxfr_pkg::PH_LENGTH: begin
				res.byte_valid = 1'b1;
				res.byte_index = cur.position;
				nxt.position   = pos_inc;
				nxt.length     = rx_byte;
				nxt.remaining  = rx_byte;
				nxt.xor_acc    = cur.xor_acc ^ rx_byte;
				nxt.phase      = slxfr_pkg::PH_TYPE;
			end
			slxfr_pkg::PH_TYPE: begin
				res.byte_valid = 1'b1;
				res.byte_index = cur.position;
				nxt.position   = pos_inc;
				nxt.xor_acc    = cur.xor_acc ^ rx_byte;
				// zero length skips straight to the checksum
				nxt.phase      = (cur.remaining == '0) ? slxfr_pkg::PH_CHECKSUM
				                                       : slxfr_pkg::PH_PAYLOAD;
			end
			slxfr_pkg::PH_PAYLOAD: begin
				res.byte_valid = 1'b1;
				res.byte_index = cur.position;
				nxt.position   = pos_inc;
				nxt.xor_acc    = cur.xor_acc ^ rx_byte;
				nxt.remaining  = cur.remaining - 8'd1;
				if (cur.remaining == 8'd1) begin
					nxt.phase = slxfr_pkg::PH_CHECKSUM;
				end
			end
			slxfr_pkg::PH_CHECKSUM: begin
				res.byte_valid = 1'b1;
				res.byte_index = cur.position;
				if (sum_ok && fits) begin
					res.frame_done   = 1'b1;
					res.frame_length = total;
				end else begin
					res.frame_error = 1'b1;
				end
				nxt.phase     = slxfr_pkg::PH_HUNT;
				nxt.position  = '0;
				nxt.remaining = '0;
			end
			default: begin
				// hunting; unused codes also land here
				nxt.phase    = slxfr_pkg::PH_HUNT;
				nxt.position = '0;
				if (rx_byte == sync_value) begin
					res.byte_valid = 1'b1;
					nxt.position   = 9'd1;
					nxt.xor_acc    = rx_byte;
					nxt.phase      = slxfr_pkg::PH_LENGTH;
				end
			end
		endcase

		// reported phase: outcome of the checksum beat wins
		if (res.frame_done) begin
			res.phase = slxfr_pkg::PH_COMPLETE;
		end else if (res.frame_error) begin
			res.phase = slxfr_pkg::PH_ERROR;
		end else begin
			res.phase = nxt.phase;
		end
	end

endmodule

[hw/rtl/slxfr_checker.sv]
// Port-level checks on the result channel.
module slxfr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [slxfr_pkg::PhaseW-1:0]   phase,
	input logic                           byte_valid,
	input logic [slxfr_pkg::PosW-1:0]     byte_index,
	input logic [slxfr_pkg::ByteW-1:0]    out_byte,
	input logic                           frame_done,
	input logic                           frame_error
);

	// stalled beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("result beat dropped or changed under stall");

	// done and error never together
	a_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_done && frame_error))
		else $error("done and error both set");

	// outcome marks only on a frame byte with the matching phase
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> byte_valid && phase == slxfr_pkg::PH_COMPLETE
			&& byte_index >= 9'd3)
		else $error("done mark without a complete frame");

	a_error_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_error |-> byte_valid && phase == slxfr_pkg::PH_ERROR)
		else $error("error mark with wrong phase");

	// a byte outside any frame reports hunting at index zero
	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> phase == slxfr_pkg::PH_HUNT && byte_index == '0)
		else $error("non-frame byte with frame position");

endmodule

bind sync_length_xor_frame_receiver_unit slxfr_checker u_slxfr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.phase       (phase),
	.byte_valid  (byte_valid),
	.byte_index  (byte_index),
	.out_byte    (out_byte),
	.frame_done  (frame_done),
	.frame_error (frame_error)
);
